[hdl/bsb_pkg.sv]
// Package: constants, types and helpers shared by the B-spline basis evaluator.
`default_nettype none
package bsb_pkg;
  localparam int unsigned MaxOrderDef  = 8;
  localparam int unsigned KnotDepthDef = 64;
  localparam logic [30:0] OneQ30       = 31'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAF_A,
    ST_LEAF_B,
    ST_LEAF_C,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_OUT
  } bsb_state_e;

  typedef struct packed {
    logic start;
    logic signed [32:0] num;
    logic signed [32:0] den;
    logic [30:0] node;
  } bsb_term_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [63:0] quot;
  } bsb_term_rsp_t;
endpackage
`default_nettype wire

[hdl/bsb_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module bsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/bsb_term_div.sv]
// Term unit: registered multiply, then 64-bit restoring serial divide, truncating.
`default_nettype none
module bsb_term_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire bsb_pkg::bsb_term_req_t req_i,
  output      bsb_pkg::bsb_term_rsp_t rsp_o
);
  import bsb_pkg::*;
  logic [1:0]  phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [32:0] dvs_q, dvs_d;
  logic [33:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic signed [32:0] num_q, num_d;
  logic signed [63:0] prod;
  logic [33:0] trial;
  logic [33:0] shifted;

  assign prod = 64'(num_q * $signed({2'b00, dvd_q[30:0]}));
  assign shifted = {rem_q[32:0], dvd_q[63]};
  assign trial = shifted - {1'b0, dvs_q};

  always_comb begin
    phase_d = phase_q;
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    neg_d = neg_q;
    zero_d = zero_q;
    num_d = num_q;
    unique case (phase_q)
      2'd0: begin
        if (req_i.start) begin
          num_d = req_i.num;
          dvd_d = {33'd0, req_i.node};
          dvs_d = req_i.den[32] ? 33'(-req_i.den) : 33'(req_i.den);
          neg_d = req_i.den[32];
          zero_d = (req_i.den == '0);
          phase_d = 2'd1;
        end
      end
      2'd1: begin
        neg_d = neg_q ^ prod[63];
        dvd_d = prod[63] ? 64'(-prod) : 64'(prod);
        rem_d = '0;
        cnt_d = '0;
        phase_d = zero_q ? 2'd3 : 2'd2;
        if (zero_q) dvd_d = '0;
      end
      2'd2: begin
        if (!trial[33]) begin
          rem_d = trial;
          dvd_d = {dvd_q[62:0], 1'b1};
        end else begin
          rem_d = shifted;
          dvd_d = {dvd_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) phase_d = 2'd3;
      end
      default: begin
        phase_d = 2'd0;
      end
    endcase
  end
  assign rsp_o.done = (phase_q == 2'd3);
  assign rsp_o.busy = (phase_q != 2'd0);
  assign rsp_o.quot = neg_q ? 64'(-dvd_q) : dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
    num_q <= num_d;
  end
endmodule
`default_nettype wire

[hdl/bspline_basis_eval_unit.sv]
// Top level: B-spline basis evaluator (Cox-de Boor) with knot RAM and term unit.
//
// Input stream s_axis: tuser = cmd (0 load knot, 1 evaluate); tdata packs
// knot_index, knot_value, eval_interval, param_value. A load is written at
// acceptance and gives no output word; loads can follow back to back.
// An evaluate gives one output word on m_axis: tdata = basis_value (Q1.30),
// tuser = range_error.
// Evaluate sequence: leaf tests read the knots one at a time (one knot RAM
// read port), then each of the r(r-1)/2 nodes takes 2 terms, each term 2 RAM
// reads and then a pass through the shared serial multiply/divide unit. A
// window past the store answers at once with range_error.
// s_axis_tready is low from acceptance until the output word is taken;
// a stalled receiver holds the block with the word in the output register.
// Reset clears control state and sets spline_order to 1; knot RAM content
// is undefined until loaded.
`default_nettype none
module bspline_basis_eval_unit #(
  parameter int unsigned MaxOrder  = bsb_pkg::MaxOrderDef,
  parameter int unsigned KnotDepth = bsb_pkg::KnotDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [5:0] knot_index, [37:6] knot_value, [43:38] eval_interval, [75:44] param_value
  input  wire logic [79:0] s_axis_tdata,
  // [0] cmd
  input  wire logic        s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [30:0] basis_value
  output      logic [31:0] m_axis_tdata,
  // [0] range_error
  output      logic        m_axis_tuser
);
  import bsb_pkg::*;
  localparam int unsigned AW = $clog2(KnotDepth);
  localparam int unsigned OW = $clog2(MaxOrder + 1);

  bsb_state_e state_q, state_d;
  logic [3:0] order_cfg_q;
  logic [OW-1:0] ord_q, ord_d, r_q, r_d, j_q, j_d;
  logic [6:0] base_q, base_d;
  logic signed [31:0] u_q, u_d;
  logic [30:0] nodes_q [MaxOrder+1];
  logic [30:0] nodes_d [MaxOrder+1];
  logic signed [31:0] ka_q, ka_d, kb_q, kb_d, kc_q, kc_d;
  logic signed [64:0] t1_q, t1_d;
  logic tsel_q, tsel_d;
  logic [30:0] res_q, res_d;
  logic err_q, err_d, ov_q, ov_d;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [6:0] rd_idx;
  logic signed [31:0] ram_rd;
  bsb_term_req_t treq;
  bsb_term_rsp_t trsp;
  logic [3:0] ord_sat;
  logic signed [64:0] sum;

  assign ram_we = s_axis_tvalid && s_axis_tready && !s_axis_tuser
                  && (32'(s_axis_tdata[5:0]) < KnotDepth);
  assign ram_waddr = AW'(s_axis_tdata[5:0]);
  assign ram_raddr = AW'(rd_idx);

  bsb_ram #(.Width(32), .Depth(KnotDepth)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(s_axis_tdata[37:6]),
    .raddr_i(ram_raddr), .rdata_o(ram_rd)
  );
  bsb_term_div u_term (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(treq), .rsp_o(trsp));

  assign ord_sat = (order_cfg_q == 4'd0) ? 4'd1 :
                   ((32'(order_cfg_q) > MaxOrder) ? 4'(MaxOrder) : order_cfg_q);
  assign sum = t1_q + 65'(trsp.quot);

  always_comb begin
    state_d = state_q;
    ord_d = ord_q; r_d = r_q; j_d = j_q; base_d = base_q; u_d = u_q;
    nodes_d = nodes_q;
    ka_d = ka_q; kb_d = kb_q; kc_d = kc_q; t1_d = t1_q; tsel_d = tsel_q;
    res_d = res_q; err_d = err_q; ov_d = ov_q;
    rd_idx = base_q + 7'(j_q);
    treq.start = 1'b0;
    treq.num = '0;
    treq.den = '0;
    treq.node = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser) begin
          ord_d = OW'(ord_sat);
          base_d = {1'b0, s_axis_tdata[43:38]};
          u_d = s_axis_tdata[75:44];
          j_d = '0;
          if (32'(s_axis_tdata[43:38]) + 32'(ord_sat) > KnotDepth - 1) begin
            res_d = '0;
            err_d = 1'b1;
            state_d = ST_OUT;
          end else begin
            err_d = 1'b0;
            state_d = ST_LEAF_A;
          end
        end
      end
      ST_LEAF_A: begin
        state_d = ST_LEAF_B;
      end
      ST_LEAF_B: begin
        rd_idx = base_q + 7'(j_q) + 7'd1;
        ka_d = ram_rd;
        state_d = ST_LEAF_C;
      end
      ST_LEAF_C: begin
        nodes_d[j_q] = (ka_q <= u_q && u_q < ram_rd) ? OneQ30 : '0;
        if (j_q + 1'b1 == ord_q) begin
          if (ord_q == OW'(1)) begin
            res_d = nodes_d[0];
            state_d = ST_OUT;
          end else begin
            r_d = OW'(2); j_d = '0; tsel_d = 1'b0;
            state_d = ST_RD0;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = ST_LEAF_A;
        end
      end
      // term 0 reads k[j], k[j+r-1]; term 1 reads k[j+1], k[j+r]
      ST_RD0: begin
        rd_idx = base_q + 7'(j_q) + 7'(tsel_q);
        state_d = ST_RD1;
      end
      ST_RD1: begin
        rd_idx = base_q + 7'(j_q) + 7'(r_q) - 7'(!tsel_q);
        ka_d = ram_rd;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        kb_d = ram_rd;
        state_d = ST_RD3;
      end
      ST_RD3: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        treq.start = 1'b1;
        treq.den = 33'(kb_q) - 33'(ka_q);
        if (!tsel_q) begin
          treq.num = 33'(u_q) - 33'(ka_q);
          treq.node = nodes_q[j_q];
        end else begin
          treq.num = 33'(kb_q) - 33'(u_q);
          treq.node = nodes_q[j_q + 1'b1];
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (trsp.done) begin
          if (!tsel_q) begin
            t1_d = 65'(trsp.quot);
            tsel_d = 1'b1;
            state_d = ST_RD0;
          end else begin
            state_d = ST_ACC;
            kc_d = ka_q;
          end
        end
      end
      ST_ACC: begin
        nodes_d[j_q] = sum[64] ? '0 : ((sum > 65'(OneQ30)) ? OneQ30 : sum[30:0]);
        tsel_d = 1'b0;
        if (32'(j_q) + 32'(r_q) >= 32'(ord_q)) begin
          if (r_q == ord_q) begin
            res_d = nodes_d[0];
            state_d = ST_OUT;
          end else begin
            r_d = r_q + 1'b1; j_d = '0;
            state_d = ST_RD0;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = ST_RD0;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    ov_d = kc_q[0] & 1'b0;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {1'b0, res_q};
  assign m_axis_tuser = err_q | ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      order_cfg_q <= 4'd1;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      if (cfg_we_i) order_cfg_q <= cfg_wdata_i;
    end
  end
  always_ff @(posedge clk_i) begin
    ord_q <= ord_d; r_q <= r_d; j_q <= j_d; base_q <= base_d; u_q <= u_d;
    nodes_q <= nodes_d;
    ka_q <= ka_d; kb_q <= kb_d; kc_q <= kc_d; t1_q <= t1_d; tsel_q <= tsel_d;
    res_q <= res_d; err_q <= err_d;
  end
endmodule
`default_nettype wire

[hdl/bsb_checker.sv]
// Port-level checker for the B-spline basis evaluator, bound to the top level.
`default_nettype none
module bsb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while word pending");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 32'h4000_0000) else $error("basis above one");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 32'd0)
    else $error("error word nonzero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
endmodule
bind bspline_basis_eval_unit bsb_checker u_bsb_checker (.*);
`default_nettype wire

[sim/tb_bspline_basis_eval_unit.sv]
// Testbench for the B-spline basis evaluator: scoreboard with its own Cox-de Boor predictor.
`timescale 1ns / 1ps

class bsb_scoreboard;
  logic [31:0] knots[64];
  logic [3:0]  order_reg;
  logic [30:0] want_basis[$];
  logic        want_err[$];
  int          n_err;
  int          n_checked;

  function new();
    order_reg = 4'd1;
    n_err = 0;
    n_checked = 0;
  endfunction

  function longint sat_unit(longint v);
    if (v < 0) return 0;
    if (v > (longint'(1) << 30)) return longint'(1) << 30;
    return v;
  endfunction

  function longint term_val(longint nd, longint node, longint den);
    if (den == 0) return 0;
    return (nd * node) / den;
  endfunction

  function longint knot_at(int idx);
    if (idx >= 64) return 0;
    return longint'($signed(knots[idx]));
  endfunction

  function longint cox_de_boor(int base, int ord, longint u);
    longint nodes[9];
    longint a, b, c, d, t1, t2;
    for (int j = 0; j < ord; j++) begin
      a = knot_at(base + j);
      b = knot_at(base + j + 1);
      nodes[j] = (a <= u && u < b) ? (longint'(1) << 30) : 0;
    end
    for (int r = 2; r <= ord; r++) begin
      for (int j = 0; j + r <= ord; j++) begin
        a = knot_at(base + j);
        b = knot_at(base + j + 1);
        c = knot_at(base + j + r - 1);
        d = knot_at(base + j + r);
        t1 = term_val(u - a, nodes[j], c - a);
        t2 = term_val(d - u, nodes[j + 1], d - b);
        nodes[j] = sat_unit(t1 + t2);
      end
    end
    return nodes[0];
  endfunction

  function void note_word(logic cmd, logic [79:0] data);
    int ord;
    int base;
    if (!cmd) begin
      knots[data[5:0]] = data[37:6];
      return;
    end
    ord = order_reg;
    if (ord < 1) ord = 1;
    if (ord > 8) ord = 8;
    base = data[43:38];
    if (base + ord > 63) begin
      want_basis.push_back('0);
      want_err.push_back(1'b1);
    end else begin
      want_basis.push_back(31'(cox_de_boor(base, ord, longint'($signed(data[75:44])))));
      want_err.push_back(1'b0);
    end
  endfunction

  function void check_word(logic [31:0] data, logic user);
    logic [30:0] eb;
    logic        ee;
    if (want_basis.size() == 0) begin
      $error("unexpected output word basis_value=%0d", data[30:0]);
      n_err++;
      return;
    end
    eb = want_basis.pop_front();
    ee = want_err.pop_front();
    n_checked++;
    if (data[30:0] !== eb) begin
      $error("basis_value expected %0d actual %0d", eb, data[30:0]);
      n_err++;
    end
    if (user !== ee) begin
      $error("range_error expected %0d actual %0d", ee, user);
      n_err++;
    end
  endfunction
endclass

module tb_bspline_basis_eval_unit;
  import bsb_pkg::*;

  localparam int WatchdogLimit = 200000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  bsb_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int idle_cycles;
  int n_sent;

  bspline_basis_eval_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // output side: stall at random, check on accept, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // tvalid stays high after an accept; it drops on idle or before a drain
  task automatic send_word(logic cmd, logic [79:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(cmd, data);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_knot(logic [5:0] idx, logic [31:0] val);
    send_word(1'b0, {4'd0, 32'd0, 6'd0, val, idx});
  endtask

  task automatic eval_basis(logic [5:0] base, logic [31:0] u);
    send_word(1'b1, {4'd0, u, base, $urandom(), 6'($urandom())});
  endtask

  task automatic drain_and_set_order(logic [3:0] ord);
    s_axis_tvalid <= 1'b0;
    while (sb.want_basis.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ord;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.order_reg = ord;
  endtask

  // ascending knots with random spacing and some repeats; a large spacing_max can wrap
  task automatic load_sorted_knots(int spacing_max);
    logic [31:0] k;
    k = 32'($signed(-32'sd65536 * $urandom_range(40)));
    for (int i = 0; i < 64; i++) begin
      load_knot(6'(i), k);
      if ($urandom_range(5) != 0) k = k + $urandom_range(spacing_max);
    end
  endtask

  function automatic logic [31:0] param_near(int base);
    logic [31:0] lo, hi;
    lo = sb.knots[base];
    hi = sb.knots[(base + 9 > 63) ? 63 : base + 9];
    if ($urandom_range(9) == 0) return $urandom();
    if ($signed(hi) <= $signed(lo)) return lo + $urandom_range(3) - 1;
    return lo + $urandom_range(32'(hi - lo));
  endfunction

  initial begin
    logic [3:0] ord;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    n_sent = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: full store, extremes, order 1, zero, over-range, window edge
    load_sorted_knots(32'h0002_0000);
    load_knot(6'd63, 32'h7FFF_FFFF);
    load_knot(6'd0, 32'h8000_0000);
    eval_basis(6'd0, 32'h8000_0000);
    eval_basis(6'd62, 32'h7FFF_FFFE);
    eval_basis(6'd63, 32'h7FFF_FFFF);
    eval_basis(6'd5, sb.knots[5]);
    eval_basis(6'd5, sb.knots[6]);
    drain_and_set_order(4'd0);
    eval_basis(6'd3, param_near(3));
    eval_basis(6'd63, 32'd0);
    drain_and_set_order(4'd15);
    eval_basis(6'd55, param_near(55));
    eval_basis(6'd56, param_near(56));
    drain_and_set_order(4'd8);
    eval_basis(6'd10, param_near(10));
    eval_basis(6'd20, 32'hFFFF_FFFF);
    // unsorted knots drive saturation
    for (int i = 30; i < 40; i++) load_knot(6'(i), $urandom());
    eval_basis(6'd30, param_near(30));
    eval_basis(6'd31, $urandom());

    // random phases; orders weighted low since order 8 is slow
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      ord = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
      drain_and_set_order(ord);
      if (ph % 3 == 0) load_sorted_knots((ph == 3) ? 32'hFFFF_FFFF >> 4 : 32'h0004_0000);
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(9) < 2)
          load_knot(6'($urandom()), $urandom_range(3) == 0 ? $urandom()
                    : sb.knots[$urandom_range(63)]);
        else begin
          int b;
          b = $urandom_range(63);
          eval_basis(6'(b), param_near(b));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.want_basis.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("Sent %0d words, checked %0d evaluations over orders 0..15 and four idle patterns",
             n_sent, sb.n_checked);
    if (sb.n_err == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

[filelist.f]
hdl/bsb_pkg.sv
hdl/bsb_ram.sv
hdl/bsb_term_div.sv
hdl/bspline_basis_eval_unit.sv
hdl/bsb_checker.sv
sim/tb_bspline_basis_eval_unit.sv
